// File: hdl/csort_pkg.sv
// shared types and constants for the cocktail shaker sorter
package csort_pkg;

    // default storage geometry
    localparam int DEPTH_DEFAULT      = 16;
    localparam int DATA_WIDTH_DEFAULT = 32;

    // fixed widths of the payload ports
    localparam int IN_WIDTH  = 32;
    localparam int OUT_WIDTH = 32;

    // sequencer states
    typedef enum logic [3:0] {
        ST_LOAD,
        ST_FWD_INIT,
        ST_FWD_HEAD,
        ST_FWD_STEP,
        ST_FWD_TAIL,
        ST_BWD_INIT,
        ST_BWD_HEAD,
        ST_BWD_STEP,
        ST_BWD_TAIL,
        ST_EMIT_RD,
        ST_EMIT_WR
    } t_state;

    // control of one result request from the engine to the output stage
    typedef struct packed {
        logic valid;
        logic end_of_run;
        logic overflow;
    } t_emit_ctl;

endpackage

// File: hdl/csort_mem.sv
// element store: one write port, one read port with registered read data
module csort_mem
    import csort_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEFAULT,
    parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT,
    localparam int IW        = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [IW-1:0]         i_waddr,
    input  logic [DATA_WIDTH-1:0] i_wdata,
    input  logic [IW-1:0]         i_raddr,
    output logic [DATA_WIDTH-1:0] o_rdata
);

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered read data
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// File: hdl/csort_engine.sv
// load, sort and readout sequencer around the element store
module csort_engine
    import csort_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEFAULT,
    parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT,
    localparam int IW        = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input request channel
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [IN_WIDTH-1:0]   i_sample_value,
    input  logic                  i_final_item,
    // memory port
    output logic                  o_mem_we,
    output logic [IW-1:0]         o_mem_waddr,
    output logic [DATA_WIDTH-1:0] o_mem_wdata,
    output logic [IW-1:0]         o_mem_raddr,
    input  logic [DATA_WIDTH-1:0] i_mem_rdata,
    // result request toward the output stage
    output t_emit_ctl             o_emit_ctl,
    output logic [DATA_WIDTH-1:0] o_emit_value,
    input  logic                  i_emit_ready
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    t_state                r_state, n_state;
    logic [CW-1:0]         r_fill, n_fill;
    logic                  r_ovf, n_ovf;
    logic [IW-1:0]         r_lo, n_lo;
    logic [IW-1:0]         r_hi, n_hi;
    logic [IW-1:0]         r_last, n_last;
    logic [IW-1:0]         r_idx, n_idx;
    logic                  r_swapped, n_swapped;
    logic [DATA_WIDTH-1:0] r_carry, n_carry;

    logic [DATA_WIDTH-1:0] sample_ext;
    logic [CW-1:0]         load_count;
    logic                  fwd_less;
    logic                  bwd_less;

    // input sample into the storage width, sign kept when widening
    generate
        if (DATA_WIDTH <= IN_WIDTH) begin : g_in_trunc
            assign sample_ext = i_sample_value[DATA_WIDTH-1:0];
        end else begin : g_in_ext
            assign sample_ext = {{(DATA_WIDTH-IN_WIDTH){i_sample_value[IN_WIDTH-1]}},
                                 i_sample_value};
        end
    endgenerate

    // signed compares of the carried element against the fresh read
    assign fwd_less = $signed(i_mem_rdata) < $signed(r_carry);
    assign bwd_less = $signed(r_carry) < $signed(i_mem_rdata);

    // element count after the current load
    assign load_count = (r_fill < FULL_COUNT) ? r_fill + CW'(1) : r_fill;

    assign o_emit_value = i_mem_rdata;

    // state and working registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_LOAD;
            r_fill    <= '0;
            r_ovf     <= 1'b0;
            r_lo      <= '0;
            r_hi      <= '0;
            r_last    <= '0;
            r_idx     <= '0;
            r_swapped <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_fill    <= n_fill;
            r_ovf     <= n_ovf;
            r_lo      <= n_lo;
            r_hi      <= n_hi;
            r_last    <= n_last;
            r_idx     <= n_idx;
            r_swapped <= n_swapped;
        end
    end

    // carried element
    always_ff @(posedge i_clk) begin
        r_carry <= n_carry;
    end

    // next state, memory accesses and result requests
    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_ovf       = r_ovf;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_last      = r_last;
        n_idx       = r_idx;
        n_swapped   = r_swapped;
        n_carry     = r_carry;
        o_in_ready  = 1'b0;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_idx;
        o_mem_wdata = r_carry;
        o_mem_raddr = r_idx;
        o_emit_ctl  = '0;

        case (r_state)
            ST_LOAD: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    // store the element, or drop it when full
                    if (r_fill < FULL_COUNT) begin
                        o_mem_we    = 1'b1;
                        o_mem_waddr = r_fill[IW-1:0];
                        o_mem_wdata = sample_ext;
                    end else begin
                        n_ovf = 1'b1;
                    end
                    n_fill = load_count;
                    if (i_final_item) begin
                        n_lo   = '0;
                        n_hi   = IW'(load_count - CW'(1));
                        n_last = '0;
                        if (load_count > CW'(1)) begin
                            n_state = ST_FWD_INIT;
                        end else begin
                            n_idx   = '0;
                            n_state = ST_EMIT_RD;
                        end
                    end
                end
            end

            // forward pass: carry the largest value up to the upper bound
            ST_FWD_INIT: begin
                o_mem_raddr = r_lo;
                n_state     = ST_FWD_HEAD;
            end

            ST_FWD_HEAD: begin
                n_carry     = i_mem_rdata;
                o_mem_raddr = r_lo + IW'(1);
                n_idx       = r_lo;
                n_swapped   = 1'b0;
                n_state     = ST_FWD_STEP;
            end

            ST_FWD_STEP: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_idx;
                if (fwd_less) begin
                    o_mem_wdata = i_mem_rdata;
                    n_last      = r_idx;
                    n_swapped   = 1'b1;
                end else begin
                    o_mem_wdata = r_carry;
                    n_carry     = i_mem_rdata;
                end
                if (r_idx + IW'(1) < r_hi) begin
                    o_mem_raddr = r_idx + IW'(2);
                    n_idx       = r_idx + IW'(1);
                end else begin
                    n_state = ST_FWD_TAIL;
                end
            end

            ST_FWD_TAIL: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_hi;
                o_mem_wdata = r_carry;
                if (!r_swapped) begin
                    n_idx   = '0;
                    n_state = ST_EMIT_RD;
                end else begin
                    n_hi = r_last;
                    if (r_last == r_lo) begin
                        n_idx   = '0;
                        n_state = ST_EMIT_RD;
                    end else begin
                        n_state = ST_BWD_INIT;
                    end
                end
            end

            // backward pass: carry the smallest value down to the lower bound
            ST_BWD_INIT: begin
                o_mem_raddr = r_hi;
                n_state     = ST_BWD_HEAD;
            end

            ST_BWD_HEAD: begin
                n_carry     = i_mem_rdata;
                o_mem_raddr = r_hi - IW'(1);
                n_idx       = r_hi;
                n_swapped   = 1'b0;
                n_state     = ST_BWD_STEP;
            end

            ST_BWD_STEP: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_idx;
                if (bwd_less) begin
                    o_mem_wdata = i_mem_rdata;
                    n_last      = r_idx;
                    n_swapped   = 1'b1;
                end else begin
                    o_mem_wdata = r_carry;
                    n_carry     = i_mem_rdata;
                end
                if (r_idx - IW'(1) > r_lo) begin
                    o_mem_raddr = r_idx - IW'(2);
                    n_idx       = r_idx - IW'(1);
                end else begin
                    n_state = ST_BWD_TAIL;
                end
            end

            ST_BWD_TAIL: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_lo;
                o_mem_wdata = r_carry;
                if (!r_swapped) begin
                    n_idx   = '0;
                    n_state = ST_EMIT_RD;
                end else begin
                    n_lo = r_last;
                    if (r_last < r_hi) begin
                        n_state = ST_FWD_INIT;
                    end else begin
                        n_idx   = '0;
                        n_state = ST_EMIT_RD;
                    end
                end
            end

            // readout in ascending address order
            ST_EMIT_RD: begin
                o_mem_raddr = r_idx;
                n_state     = ST_EMIT_WR;
            end

            ST_EMIT_WR: begin
                o_mem_raddr           = r_idx;
                o_emit_ctl.valid      = 1'b1;
                o_emit_ctl.end_of_run = (CW'(r_idx) + CW'(1)) == r_fill;
                o_emit_ctl.overflow   = r_ovf;
                if (i_emit_ready) begin
                    if (o_emit_ctl.end_of_run) begin
                        n_fill  = '0;
                        n_ovf   = 1'b0;
                        n_lo    = '0;
                        n_hi    = '0;
                        n_last  = '0;
                        n_idx   = '0;
                        n_state = ST_LOAD;
                    end else begin
                        n_idx   = r_idx + IW'(1);
                        n_state = ST_EMIT_RD;
                    end
                end
            end

            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

endmodule

// File: hdl/csort_out.sv
// output register for result requests, with sign extension or truncation to the port width
module csort_out
    import csort_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_emit_ctl             i_emit_ctl,
    input  logic [DATA_WIDTH-1:0] i_emit_value,
    output logic                  o_emit_ready,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [OUT_WIDTH-1:0]  o_sorted_value,
    output logic                  o_end_of_run,
    output logic                  o_overflow
);

    logic                 r_valid;
    logic [OUT_WIDTH-1:0] r_value;
    logic                 r_eor;
    logic                 r_ovf;
    logic [OUT_WIDTH-1:0] value_ext;
    logic                 load;

    // stored element to the output width
    generate
        if (DATA_WIDTH >= OUT_WIDTH) begin : g_out_trunc
            assign value_ext = i_emit_value[OUT_WIDTH-1:0];
        end else begin : g_out_ext
            assign value_ext = {{(OUT_WIDTH-DATA_WIDTH){i_emit_value[DATA_WIDTH-1]}},
                                i_emit_value};
        end
    endgenerate

    // register is free when empty or being taken
    assign o_emit_ready = !r_valid || i_out_ready;
    assign load         = i_emit_ctl.valid && o_emit_ready;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_value <= value_ext;
            r_eor   <= i_emit_ctl.end_of_run;
            r_ovf   <= i_emit_ctl.overflow;
        end
    end

    assign o_out_valid    = r_valid;
    assign o_sorted_value = r_value;
    assign o_end_of_run   = r_eor;
    assign o_overflow     = r_ovf;

endmodule

// File: hdl/cocktail_shaker_sorter.sv
// top level of the cocktail shaker sorter
// Collects up to DEPTH signed elements, one per cycle, into a single-port-pair
// memory until a request marked final arrives, then sorts them in place with
// alternating forward and backward bubble passes and streams them out in
// ascending order; the last result carries end_of_run, and every result of a
// set that lost elements to a full store carries overflow. A pass over a span
// of s adjacent pairs reads the first element, makes s compare-and-write steps
// and writes the carried element; sorting ends early after a pass with no
// swap. Readout reads each result from the memory and then offers it to the
// output register, holding while that register is not free. New input is taken
// only while loading; the final result may still wait in the output register
// while the next set loads.
module cocktail_shaker_sorter
    import csort_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEFAULT,
    parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input requests
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic signed [IN_WIDTH-1:0]  i_sample_value,
    input  logic                        i_final_item,
    // result requests
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic signed [OUT_WIDTH-1:0] o_sorted_value,
    output logic                        o_end_of_run,
    output logic                        o_overflow
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic                  mem_we;
    logic [IW-1:0]         mem_waddr;
    logic [DATA_WIDTH-1:0] mem_wdata;
    logic [IW-1:0]         mem_raddr;
    logic [DATA_WIDTH-1:0] mem_rdata;
    t_emit_ctl             emit_ctl;
    logic [DATA_WIDTH-1:0] emit_value;
    logic                  emit_ready;
    logic [OUT_WIDTH-1:0]  sorted_value;

    // element store
    csort_mem #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // load, sort and readout sequencer
    csort_engine #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_engine (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_sample_value (i_sample_value),
        .i_final_item   (i_final_item),
        .o_mem_we       (mem_we),
        .o_mem_waddr    (mem_waddr),
        .o_mem_wdata    (mem_wdata),
        .o_mem_raddr    (mem_raddr),
        .i_mem_rdata    (mem_rdata),
        .o_emit_ctl     (emit_ctl),
        .o_emit_value   (emit_value),
        .i_emit_ready   (emit_ready)
    );

    // output register
    csort_out #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_out (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_emit_ctl     (emit_ctl),
        .i_emit_value   (emit_value),
        .o_emit_ready   (emit_ready),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_sorted_value (sorted_value),
        .o_end_of_run   (o_end_of_run),
        .o_overflow     (o_overflow)
    );

    assign o_sorted_value = sorted_value;

endmodule

// File: test/cocktail_shaker_sorter_tb.sv
// testbench for the cocktail shaker sorter: random and directed sets checked against a sort predictor
`timescale 1ns / 1ps

module cocktail_shaker_sorter_tb;
    import csort_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 10;
    localparam int DRAIN_CYCLES = 400;
    localparam int WATCHDOG_NS  = 3_000_000;
    localparam int HOLD_CYCLES  = 300;

    localparam logic signed [IN_WIDTH-1:0] MAX_SAMPLE = 32'h7FFF_FFFF;
    localparam logic signed [IN_WIDTH-1:0] MIN_SAMPLE = 32'h8000_0000;

    typedef struct packed {
        logic signed [OUT_WIDTH-1:0] value;
        logic                        end_of_run;
        logic                        overflow;
    } t_sorted_result;

    logic                        i_clk          = 1'b0;
    logic                        i_rst_n        = 1'b0;
    logic                        i_in_valid     = 1'b0;
    logic                        o_in_ready;
    logic signed [IN_WIDTH-1:0]  i_sample_value = '0;
    logic                        i_final_item   = 1'b0;
    logic                        o_out_valid;
    logic                        i_out_ready    = 1'b0;
    logic signed [OUT_WIDTH-1:0] o_sorted_value;
    logic                        o_end_of_run;
    logic                        o_overflow;

    // predictor state: the set being collected and the results still owed
    logic signed [DATA_WIDTH_DEFAULT-1:0] held_values [DEPTH_DEFAULT];
    int                                   held_count   = 0;
    bit                                   held_dropped = 1'b0;
    t_sorted_result                       owed_results [$];

    // traffic shaping and bookkeeping
    int          sender_idle_pct = 0;
    int          stall_pct       = 0;
    int          hold_cycles     = 0;
    int unsigned mismatch_count  = 0;
    int unsigned requests_sent   = 0;
    int unsigned sets_sent       = 0;
    int unsigned overflow_sets   = 0;
    int unsigned results_checked = 0;

    cocktail_shaker_sorter i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_sample_value (i_sample_value),
        .i_final_item   (i_final_item),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_sorted_value (o_sorted_value),
        .o_end_of_run   (o_end_of_run),
        .o_overflow     (o_overflow)
    );

    // clock
    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // bidirectional bubble passes over the collected set, bounds shrink to the last swap
    function automatic void shake_held_values();
        int lo;
        int hi;
        int last_swap;
        int idx;
        bit swapped;
        logic signed [DATA_WIDTH_DEFAULT-1:0] tmp;
        lo        = 0;
        hi        = held_count - 1;
        last_swap = 0;
        while (lo < hi) begin
            swapped = 1'b0;
            for (idx = lo; idx < hi; idx++) begin
                if (held_values[idx + 1] < held_values[idx]) begin
                    tmp                  = held_values[idx];
                    held_values[idx]     = held_values[idx + 1];
                    held_values[idx + 1] = tmp;
                    last_swap            = idx;
                    swapped              = 1'b1;
                end
            end
            if (!swapped) break;
            hi      = last_swap;
            swapped = 1'b0;
            for (idx = hi; idx > lo; idx--) begin
                if (held_values[idx] < held_values[idx - 1]) begin
                    tmp                  = held_values[idx - 1];
                    held_values[idx - 1] = held_values[idx];
                    held_values[idx]     = tmp;
                    last_swap            = idx;
                    swapped              = 1'b1;
                end
            end
            if (!swapped) break;
            lo = last_swap;
        end
    endfunction

    // collect one accepted request, emit the sorted set when it is the last one
    function automatic void collect_sample(logic signed [IN_WIDTH-1:0] sample, logic last);
        t_sorted_result res;
        if (held_count < DEPTH_DEFAULT) begin
            held_values[held_count] = sample[DATA_WIDTH_DEFAULT-1:0];
            held_count++;
        end else begin
            held_dropped = 1'b1;
        end
        if (!last) return;
        shake_held_values();
        for (int k = 0; k < held_count; k++) begin
            res.value      = held_values[k];
            res.end_of_run = (k == held_count - 1);
            res.overflow   = held_dropped;
            owed_results.push_back(res);
        end
        sets_sent++;
        if (held_dropped) overflow_sets++;
        held_count   = 0;
        held_dropped = 1'b0;
    endfunction

    // compare one accepted result with the oldest owed one
    function automatic void check_result();
        t_sorted_result exp;
        results_checked++;
        if (owed_results.size() == 0) begin
            $error("unexpected result: sorted_value=%0d end_of_run=%0b overflow=%0b",
                   o_sorted_value, o_end_of_run, o_overflow);
            mismatch_count++;
            return;
        end
        exp = owed_results.pop_front();
        if (o_sorted_value !== exp.value) begin
            $error("sorted_value: expected %0d, got %0d", exp.value, o_sorted_value);
            mismatch_count++;
        end
        if (o_end_of_run !== exp.end_of_run) begin
            $error("end_of_run: expected %0b, got %0b", exp.end_of_run, o_end_of_run);
            mismatch_count++;
        end
        if (o_overflow !== exp.overflow) begin
            $error("overflow: expected %0b, got %0b", exp.overflow, o_overflow);
            mismatch_count++;
        end
    endfunction

    // result side: check accepted results, then pick ready for the next cycle
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) check_result();
            if (hold_cycles > 0) begin
                hold_cycles--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // offer one request after a random gap and wait for it to be taken
    task automatic send_sample(input logic signed [IN_WIDTH-1:0] sample, input logic last);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_sample_value <= sample;
        i_final_item   <= last;
        do @(posedge i_clk); while (!o_in_ready);
        collect_sample(sample, last);
        requests_sent++;
    endtask

    // mix of extremes, clustered small values (duplicates) and full-range values
    function automatic logic signed [IN_WIDTH-1:0] random_sample();
        case ($urandom_range(9))
            0:       return MIN_SAMPLE;
            1:       return MAX_SAMPLE;
            2, 3, 4: return $signed($urandom_range(15)) - 8;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_random_set(input int count);
        for (int k = 0; k < count; k++) send_sample(random_sample(), k == count - 1);
    endtask

    // extremes, single elements, duplicates and an already sorted set
    task automatic test_directed_cases();
        logic signed [IN_WIDTH-1:0] mixed [7];
        logic signed [IN_WIDTH-1:0] dups  [4];
        sender_idle_pct = 0;
        stall_pct       = 0;
        mixed = '{MAX_SAMPLE, MIN_SAMPLE, -1, 0, 1, 32'h5555_5555, 32'hAAAA_AAAA};
        dups  = '{5, 5, -5, 5};
        send_sample(MAX_SAMPLE, 1'b1);
        send_sample(MIN_SAMPLE, 1'b1);
        foreach (mixed[k]) send_sample(mixed[k], k == 6);
        foreach (dups[k]) send_sample(dups[k], k == 3);
        for (int k = 1; k <= 3; k++) send_sample(k, k == 3);
    endtask

    // store filled exactly, then overrun including a dropped final request
    task automatic test_store_full();
        send_random_set(DEPTH_DEFAULT);
        send_random_set(DEPTH_DEFAULT + 3);
    endtask

    // random sets under one idling profile, mostly small, some full or overrun
    task automatic test_random_sets(input int idle_pct, input int stall, input int quota);
        int sent_here;
        sender_idle_pct = idle_pct;
        stall_pct       = stall;
        sent_here       = 0;
        while (sent_here < quota) begin
            case ($urandom_range(9))
                0:       begin send_random_set(DEPTH_DEFAULT);
                               sent_here += DEPTH_DEFAULT; end
                1:       begin send_random_set(DEPTH_DEFAULT + 1 + $urandom_range(3));
                               sent_here += DEPTH_DEFAULT + 1; end
                default: begin send_random_set(1 + $urandom_range(7));
                               sent_here += 4; end
            endcase
        end
    endtask

    // long receiver hold-off while requests keep coming, so the input stalls
    task automatic test_output_hold();
        sender_idle_pct = 0;
        stall_pct       = 0;
        hold_cycles     = HOLD_CYCLES;
        send_random_set(12);
        send_random_set(12);
    endtask

    // run limit
    initial begin
        #(WATCHDOG_NS);
        $error("run did not finish in time");
        $display("Mismatches found");
        $finish;
    end

    // test sequence
    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_cases();
        test_store_full();
        test_random_sets(0, 0, 60);
        test_random_sets(78, 0, 60);
        test_random_sets(0, 78, 60);
        test_random_sets(12, 12, 60);
        test_output_hold();
        i_in_valid <= 1'b0;
        while (owed_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("sent %0d requests in %0d sets (%0d overrun the store)",
                 requests_sent, sets_sent, overflow_sets);
        $display("checked %0d results under four idling profiles and a long output hold",
                 results_checked);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// File: files.f
hdl/csort_pkg.sv
hdl/csort_mem.sv
hdl/csort_engine.sv
hdl/csort_out.sv
hdl/cocktail_shaker_sorter.sv
test/cocktail_shaker_sorter_tb.sv
